### rtl/signed_binary_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_binary_to_decimal_ascii
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define SBDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SBDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Widths, character codes and shared types of the decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 6;
   localparam int DIGITS        = 10;
   localparam int DIGIT_W       = 4;
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);
   localparam int IDX_W         = $clog2(DIGITS);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic                       neg;
      logic [IDX_W-1:0]           top;
      digit_type [DIGITS-1:0]     digits;
   } conv_result_type;

   typedef struct packed {
      logic            valid;
      conv_result_type data;
   } conv_out_type;

   // shift-and-add-3 correction ahead of each shift
   function automatic digit_type dabble_adjust(input digit_type d);
      dabble_adjust = (d >= digit_type'(5)) ? d + digit_type'(3) : d;
   endfunction

endpackage

`default_nettype wire

### rtl/sbda_if.sv
// ----------------------------------------------------------------------------
// sbda_req_if / sbda_rsp_if
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbda_req_if;
   import sbda_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   import sbda_pkg::*;
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   character;
   logic                last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### rtl/sbda_cell.sv
// ----------------------------------------------------------------------------
// sbda_cell
// One BCD digit of the double-dabble chain, four shift steps per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_cell (
   input  wire logic                               clock,
   input  wire logic                               clear,
   input  wire logic                               step,
   input  wire logic [sbda_pkg::BITS_PER_STEP-1:0] carry_in,
   output logic [sbda_pkg::BITS_PER_STEP-1:0]      carry_out,
   output sbda_pkg::digit_type                     digit
);
   import sbda_pkg::*;

   digit_type digit_ff;
   digit_type digit_in;
   digit_type work;

   // highest carry bit is the first one shifted in
   always_comb begin
      work = digit_ff;
      for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
         work         = dabble_adjust(work);
         carry_out[k] = work[DIGIT_W-1];
         work         = {work[DIGIT_W-2:0], carry_in[k]};
      end
   end

   always_comb begin
      if (clear) begin
         digit_in = '0;
      end else if (step) begin
         digit_in = work;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

### rtl/sbda_conv.sv
// ----------------------------------------------------------------------------
// sbda_conv
// Takes a signed value, forms its magnitude and runs it through the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_conv (
   input  wire logic              clock,
   input  wire logic              reset,
   sbda_req_if.sink               req,
   input  wire logic              take,
   output sbda_pkg::conv_out_type result
);
   import sbda_pkg::*;

   logic                busy_ff, busy_in;
   logic                full_ff, full_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                accept;
   logic [VALUE_W-1:0]  value_mag;
   logic [BITS_PER_STEP-1:0] chain [DIGITS+1];
   digit_type [DIGITS-1:0]   digits;
   logic [IDX_W-1:0]    top;

   assign req.ready = !busy_ff && (!full_ff || take);
   assign accept    = req.valid && req.ready;

   // 32 bits hold the magnitude of the most negative value as well
   assign value_mag = req.value[VALUE_W-1] ? (~req.value) + VALUE_W'(1) : req.value;

   always_comb begin
      busy_in = busy_ff;
      full_in = full_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      step_in = step_ff;
      if (take) begin
         full_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         neg_in  = req.value[VALUE_W-1];
         mag_in  = value_mag;
         step_in = '0;
      end else if (busy_ff) begin
         mag_in  = mag_ff << BITS_PER_STEP;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         full_ff <= full_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      step_ff <= step_in;
   end

   assign chain[0] = mag_ff[VALUE_W-1 -: BITS_PER_STEP];

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      sbda_cell u_cell (
         .clock     (clock),
         .clear     (accept),
         .step      (busy_ff),
         .carry_in  (chain[i]),
         .carry_out (chain[i+1]),
         .digit     (digits[i])
      );
   end

   // most significant non-zero digit; zero leaves the units digit
   always_comb begin
      top = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (digits[i] != '0) begin
            top = IDX_W'(i);
         end
      end
   end

   assign result.valid       = full_ff;
   assign result.data.neg    = neg_ff;
   assign result.data.top    = top;
   assign result.data.digits = digits;

endmodule

`default_nettype wire

### rtl/sbda_emit.sv
// ----------------------------------------------------------------------------
// sbda_emit
// Holds one converted value and sends its characters, sign first.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sbda_pkg::conv_out_type result,
   output logic                   take,
   sbda_rsp_if.source             rsp
);
   import sbda_pkg::*;

   logic                    active_ff, active_in;
   logic                    sign_ff, sign_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   digit_type [DIGITS-1:0]  digits_ff, digits_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic                    last_ff, last_in;

   logic                    advance;

   assign take    = result.valid && !active_ff;
   assign advance = active_ff && (!out_valid_ff || rsp.ready);

   always_comb begin
      active_in    = active_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (take) begin
         active_in = 1'b1;
         sign_in   = result.data.neg;
         idx_in    = result.data.top;
         digits_in = result.data.digits;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         if (sign_ff) begin
            char_in = CHAR_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            char_in = CHAR_ZERO + CHAR_W'(digits_ff[idx_ff]);
            last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               active_in = 1'b0;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      sign_ff   <= sign_in;
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

endmodule

`default_nettype wire

### rtl/signed_binary_to_decimal_ascii.sv
// A new value is taken once the last conversion is done and its result is
// handed to the character output; its pass through the ten-cell digit chain
// (4 bits a cycle) then overlaps the output of the last value's characters,
// of which there are up to 11.
// Reset: synchronous, clears the control flags; digit and payload registers
// are not reset. No clearing pass.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_binary_to_decimal_ascii_macros.svh"

module signed_binary_to_decimal_ascii (
   input  wire logic  clock,
   input  wire logic  reset,
   sbda_req_if.sink   req,
   sbda_rsp_if.source rsp
);
   import sbda_pkg::*;

   conv_out_type conv_out;
   logic         take;

   sbda_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .take   (take),
      .result (conv_out)
   );

   sbda_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .result (conv_out),
      .take   (take),
      .rsp    (rsp)
   );

   // input is not taken while a conversion runs, so no back-to-back input
   `SBDA_ASSERT_NEXT(a_req_gap, clock, reset, req.valid && req.ready, !req.ready, "input accepted twice in a row")
   // characters of one value follow without a gap
   `SBDA_ASSERT_NEXT(a_rsp_run, clock, reset, rsp.valid && rsp.ready && !rsp.last, rsp.valid, "gap inside a character run")
   // a handed-over result is no longer shown as valid in the next cycle
   `SBDA_ASSERT_NEXT(a_take_once, clock, reset, take, !conv_out.valid, "converted result handed over twice")
   // while a result waits, the converter is not taking input unless handing over
   `SBDA_ASSERT_SAME(a_hold_full, clock, reset, conv_out.valid && !take, !req.ready, "input taken over a waiting result")

endmodule

`default_nettype wire
